@@ rtl/sbo_pkg.sv @@
// ============================================================================
// sbo_pkg - shared types and constants for the segment/box overlap test
// Widths of the internal arithmetic, register map codes and the structs that
// carry box settings and per-item intermediate results between stages.
// ============================================================================
package sbo_pkg;

    // Widest coordinate kept; narrower settings sign-extend up to this.
    localparam int C_CRD_W           = 32;
    localparam int C_COORD_WIDTH_DEF = 32;
    // Difference of two coordinates.
    localparam int C_DIF_W  = C_CRD_W + 1;
    // Product of two differences and the orientation (difference of two).
    localparam int C_PRD_W  = 2 * C_DIF_W;
    localparam int C_ORI_W  = C_PRD_W + 1;
    // Tolerance widths.
    localparam int C_TOLC_W = 31;
    localparam int C_TOLA_W = 63;
    // Coordinate plus or minus coordinate tolerance.
    localparam int C_EXT_W  = C_CRD_W + 2;

    // Register port: 64-bit data, registers on 8-byte steps.
    localparam int C_CFG_DW  = 64;
    localparam int C_IDX_W   = 3;
    localparam int C_IDX_LSB = 3;
    localparam int C_CFG_AW  = C_IDX_W + C_IDX_LSB;

    typedef logic signed [C_CRD_W-1:0] t_crd;
    typedef logic signed [C_DIF_W-1:0] t_dif;
    typedef logic signed [C_EXT_W-1:0] t_ext;

    typedef enum logic [C_IDX_W-1:0] {
        REG_BOX_X_MIN   = 3'd0,
        REG_BOX_X_MAX   = 3'd1,
        REG_BOX_Y_MIN   = 3'd2,
        REG_BOX_Y_MAX   = 3'd3,
        REG_BOX_Z_MIN   = 3'd4,
        REG_BOX_Z_MAX   = 3'd5,
        REG_COORD_TOL   = 3'd6,
        REG_AREA_TOL    = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        DEC_NONE   = 2'd0,
        DEC_DEGEN  = 2'd1,
        DEC_POINT  = 2'd2,
        DEC_EDGE   = 2'd3
    } t_decide;

    // Box settings plus values derived from them by the register block.
    typedef struct packed {
        t_crd                  x_min;
        t_crd                  x_max;
        t_crd                  y_min;
        t_crd                  y_max;
        t_dif                  box_dx;
        t_dif                  box_dy;
        t_ext                  x_min_lo;
        t_ext                  x_min_hi;
        t_ext                  x_max_lo;
        t_ext                  x_max_hi;
        t_ext                  y_min_lo;
        t_ext                  y_min_hi;
        t_ext                  y_max_lo;
        t_ext                  y_max_hi;
        t_ext                  x_span_lo;
        t_ext                  x_span_hi;
        t_ext                  y_span_lo;
        t_ext                  y_span_hi;
        logic [C_TOLC_W-1:0]   tol_c;
        logic [C_TOLA_W-1:0]   tol_a;
        logic                  degen;
    } t_box_cfg;

    // Range flags, bit j refers to segment endpoint j (or box min/max).
    typedef struct packed {
        logic [1:0] pt_in;       // endpoint inside grown box
        logic [1:0] kx_in;       // box x_min / x_max inside segment x extent
        logic [1:0] ky_in;       // box y_min / y_max inside segment y extent
        logic [1:0] x_span;      // endpoint x inside box x extent
        logic [1:0] y_span;
        logic [1:0] x_near_min;  // endpoint x within tolerance of x_min
        logic [1:0] x_near_max;
        logic [1:0] y_near_min;
        logic [1:0] y_near_max;
    } t_prep_flags;

    // Differences feeding the orientation products.
    typedef struct packed {
        t_dif        seg_dx;
        t_dif        seg_dy;
        t_dif        kx_min;   // x_min - x1
        t_dif        kx_max;   // x_max - x1
        t_dif        ky_min;   // y_min - y1
        t_dif        ky_max;   // y_max - y1
        t_dif        ed0_p0;   // yj - y_min
        t_dif        ed0_p1;
        t_dif        ed1_p0;   // x_max - xj
        t_dif        ed1_p1;
        t_dif        ed2_p0;   // y_max - yj
        t_dif        ed2_p1;
        t_dif        ed3_p0;   // xj - x_min
        t_dif        ed3_p1;
        t_prep_flags flags;
    } t_prep_data;

    // Orientation signs: corners k0..k3 against the segment, and
    // each endpoint against edges e0..e3.
    typedef struct packed {
        logic [3:0]  k_pos;
        logic [3:0]  k_neg;
        logic [3:0]  e_pos0;
        logic [3:0]  e_neg0;
        logic [3:0]  e_pos1;
        logic [3:0]  e_neg1;
        t_prep_flags flags;
    } t_sign_set;

endpackage

@@ rtl/sbo_cfg_regs.sv @@
// ============================================================================
// sbo_cfg_regs - box and tolerance registers
// APB-style write/read port; registers the derived box extents each cycle.
// ============================================================================
module sbo_cfg_regs #(
    parameter int COORD_W = sbo_pkg::C_COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbo_pkg::C_CFG_AW-1:0]  paddr,
    input  logic [sbo_pkg::C_CFG_DW-1:0]  pwdata,
    output logic [sbo_pkg::C_CFG_DW-1:0]  prdata,
    output logic                          pready,
    output sbo_pkg::t_box_cfg             o_cfg
);
    import sbo_pkg::*;

    logic [COORD_W-1:0]   r_x_min, r_x_max, r_y_min, r_y_max, r_z_min, r_z_max;
    logic [C_TOLC_W-1:0]  r_tol_c;
    logic [C_TOLA_W-1:0]  r_tol_a;
    t_box_cfg             r_cfg;
    t_box_cfg             n_cfg;

    logic                 w_wr;
    t_reg_idx             w_idx;
    t_crd                 w_xmn, w_xmx, w_ymn, w_ymx, w_zmn, w_zmx;
    t_ext                 w_xmn_e, w_xmx_e, w_ymn_e, w_ymx_e, w_tc;
    t_ext                 w_xlo, w_xhi, w_ylo, w_yhi;
    t_dif                 w_bdx, w_bdy;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = t_reg_idx'(paddr[C_CFG_AW-1:C_IDX_LSB]);

    // Write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_min <= '0;
            r_x_max <= '0;
            r_y_min <= '0;
            r_y_max <= '0;
            r_z_min <= '0;
            r_z_max <= '0;
            r_tol_c <= '0;
            r_tol_a <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_BOX_X_MIN: r_x_min <= pwdata[COORD_W-1:0];
                REG_BOX_X_MAX: r_x_max <= pwdata[COORD_W-1:0];
                REG_BOX_Y_MIN: r_y_min <= pwdata[COORD_W-1:0];
                REG_BOX_Y_MAX: r_y_max <= pwdata[COORD_W-1:0];
                REG_BOX_Z_MIN: r_z_min <= pwdata[COORD_W-1:0];
                REG_BOX_Z_MAX: r_z_max <= pwdata[COORD_W-1:0];
                REG_COORD_TOL: r_tol_c <= pwdata[C_TOLC_W-1:0];
                REG_AREA_TOL:  r_tol_a <= pwdata[C_TOLA_W-1:0];
            endcase
        end
    end

    // Sign-extend coordinates to the full internal width
    assign w_xmn = C_CRD_W'(signed'(r_x_min));
    assign w_xmx = C_CRD_W'(signed'(r_x_max));
    assign w_ymn = C_CRD_W'(signed'(r_y_min));
    assign w_ymx = C_CRD_W'(signed'(r_y_max));
    assign w_zmn = C_CRD_W'(signed'(r_z_min));
    assign w_zmx = C_CRD_W'(signed'(r_z_max));

    // Read back
    always_comb begin
        unique case (w_idx)
            REG_BOX_X_MIN: prdata = C_CFG_DW'(w_xmn);
            REG_BOX_X_MAX: prdata = C_CFG_DW'(w_xmx);
            REG_BOX_Y_MIN: prdata = C_CFG_DW'(w_ymn);
            REG_BOX_Y_MAX: prdata = C_CFG_DW'(w_ymx);
            REG_BOX_Z_MIN: prdata = C_CFG_DW'(w_zmn);
            REG_BOX_Z_MAX: prdata = C_CFG_DW'(w_zmx);
            REG_COORD_TOL: prdata = C_CFG_DW'(r_tol_c);
            REG_AREA_TOL:  prdata = C_CFG_DW'(r_tol_a);
        endcase
    end

    // Derive extents grown by the coordinate tolerance
    assign w_xmn_e = C_EXT_W'(w_xmn);
    assign w_xmx_e = C_EXT_W'(w_xmx);
    assign w_ymn_e = C_EXT_W'(w_ymn);
    assign w_ymx_e = C_EXT_W'(w_ymx);
    assign w_tc    = C_EXT_W'(r_tol_c);
    assign w_xlo   = (w_xmx < w_xmn) ? w_xmx_e : w_xmn_e;
    assign w_xhi   = (w_xmx < w_xmn) ? w_xmn_e : w_xmx_e;
    assign w_ylo   = (w_ymx < w_ymn) ? w_ymx_e : w_ymn_e;
    assign w_yhi   = (w_ymx < w_ymn) ? w_ymn_e : w_ymx_e;
    assign w_bdx   = C_DIF_W'(w_xmx) - C_DIF_W'(w_xmn);
    assign w_bdy   = C_DIF_W'(w_ymx) - C_DIF_W'(w_ymn);

    always_comb begin
        n_cfg           = r_cfg;
        n_cfg.x_min     = w_xmn;
        n_cfg.x_max     = w_xmx;
        n_cfg.y_min     = w_ymn;
        n_cfg.y_max     = w_ymx;
        n_cfg.box_dx    = w_bdx;
        n_cfg.box_dy    = w_bdy;
        n_cfg.x_min_lo  = w_xmn_e - w_tc;
        n_cfg.x_min_hi  = w_xmn_e + w_tc;
        n_cfg.x_max_lo  = w_xmx_e - w_tc;
        n_cfg.x_max_hi  = w_xmx_e + w_tc;
        n_cfg.y_min_lo  = w_ymn_e - w_tc;
        n_cfg.y_min_hi  = w_ymn_e + w_tc;
        n_cfg.y_max_lo  = w_ymx_e - w_tc;
        n_cfg.y_max_hi  = w_ymx_e + w_tc;
        n_cfg.x_span_lo = w_xlo - w_tc;
        n_cfg.x_span_hi = w_xhi + w_tc;
        n_cfg.y_span_lo = w_ylo - w_tc;
        n_cfg.y_span_hi = w_yhi + w_tc;
        n_cfg.tol_c     = r_tol_c;
        n_cfg.tol_a     = r_tol_a;
        n_cfg.degen     = !((w_xmx > w_xmn) || (w_ymx > w_ymn) || (w_zmx > w_zmn));
    end

    // Hold derived settings; reset matches an all-zero (degenerate) box
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= '0;
            r_cfg.degen <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/sbo_prep.sv @@
// ============================================================================
// sbo_prep - first work stage
// Forms coordinate differences and all range flags for one segment.
// ============================================================================
module sbo_prep #(
    parameter int COORD_W = sbo_pkg::C_COORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [COORD_W-1:0]   i_x1,
    input  logic [COORD_W-1:0]   i_y1,
    input  logic [COORD_W-1:0]   i_x2,
    input  logic [COORD_W-1:0]   i_y2,
    input  sbo_pkg::t_box_cfg    i_cfg,
    output sbo_pkg::t_prep_data  o_prep
);
    import sbo_pkg::*;

    t_prep_data r_prep;
    t_prep_data n_prep;

    t_crd w_x1, w_y1, w_x2, w_y2;
    t_crd w_bxmn, w_bxmx, w_bymn, w_bymx;
    t_ext w_x1e, w_y1e, w_x2e, w_y2e, w_tc;
    t_ext w_x1lo, w_x1hi, w_x2lo, w_x2hi, w_y1lo, w_y1hi, w_y2lo, w_y2hi;
    t_ext w_bxmn_e, w_bxmx_e, w_bymn_e, w_bymx_e;
    t_ext w_xmnlo, w_xmnhi, w_xmxlo, w_xmxhi, w_ymnlo, w_ymnhi, w_ymxlo, w_ymxhi;
    t_ext w_xslo, w_xshi, w_yslo, w_yshi;

    // Sign-extend endpoints and unpack settings
    assign w_x1 = C_CRD_W'(signed'(i_x1));
    assign w_y1 = C_CRD_W'(signed'(i_y1));
    assign w_x2 = C_CRD_W'(signed'(i_x2));
    assign w_y2 = C_CRD_W'(signed'(i_y2));
    assign w_bxmn = i_cfg.x_min;
    assign w_bxmx = i_cfg.x_max;
    assign w_bymn = i_cfg.y_min;
    assign w_bymx = i_cfg.y_max;
    assign w_xmnlo = i_cfg.x_min_lo;
    assign w_xmnhi = i_cfg.x_min_hi;
    assign w_xmxlo = i_cfg.x_max_lo;
    assign w_xmxhi = i_cfg.x_max_hi;
    assign w_ymnlo = i_cfg.y_min_lo;
    assign w_ymnhi = i_cfg.y_min_hi;
    assign w_ymxlo = i_cfg.y_max_lo;
    assign w_ymxhi = i_cfg.y_max_hi;
    assign w_xslo  = i_cfg.x_span_lo;
    assign w_xshi  = i_cfg.x_span_hi;
    assign w_yslo  = i_cfg.y_span_lo;
    assign w_yshi  = i_cfg.y_span_hi;

    assign w_x1e = C_EXT_W'(w_x1);
    assign w_y1e = C_EXT_W'(w_y1);
    assign w_x2e = C_EXT_W'(w_x2);
    assign w_y2e = C_EXT_W'(w_y2);
    assign w_tc  = C_EXT_W'(i_cfg.tol_c);
    assign w_bxmn_e = C_EXT_W'(w_bxmn);
    assign w_bxmx_e = C_EXT_W'(w_bxmx);
    assign w_bymn_e = C_EXT_W'(w_bymn);
    assign w_bymx_e = C_EXT_W'(w_bymx);

    // Grow each endpoint by the tolerance; min-t <= v iff some end-t <= v
    assign w_x1lo = w_x1e - w_tc;
    assign w_x1hi = w_x1e + w_tc;
    assign w_x2lo = w_x2e - w_tc;
    assign w_x2hi = w_x2e + w_tc;
    assign w_y1lo = w_y1e - w_tc;
    assign w_y1hi = w_y1e + w_tc;
    assign w_y2lo = w_y2e - w_tc;
    assign w_y2hi = w_y2e + w_tc;

    always_comb begin
        // Differences for the orientation products
        n_prep.seg_dx = C_DIF_W'(w_x2) - C_DIF_W'(w_x1);
        n_prep.seg_dy = C_DIF_W'(w_y2) - C_DIF_W'(w_y1);
        n_prep.kx_min = C_DIF_W'(w_bxmn) - C_DIF_W'(w_x1);
        n_prep.kx_max = C_DIF_W'(w_bxmx) - C_DIF_W'(w_x1);
        n_prep.ky_min = C_DIF_W'(w_bymn) - C_DIF_W'(w_y1);
        n_prep.ky_max = C_DIF_W'(w_bymx) - C_DIF_W'(w_y1);
        n_prep.ed0_p0 = C_DIF_W'(w_y1) - C_DIF_W'(w_bymn);
        n_prep.ed0_p1 = C_DIF_W'(w_y2) - C_DIF_W'(w_bymn);
        n_prep.ed1_p0 = C_DIF_W'(w_bxmx) - C_DIF_W'(w_x1);
        n_prep.ed1_p1 = C_DIF_W'(w_bxmx) - C_DIF_W'(w_x2);
        n_prep.ed2_p0 = C_DIF_W'(w_bymx) - C_DIF_W'(w_y1);
        n_prep.ed2_p1 = C_DIF_W'(w_bymx) - C_DIF_W'(w_y2);
        n_prep.ed3_p0 = C_DIF_W'(w_x1) - C_DIF_W'(w_bxmn);
        n_prep.ed3_p1 = C_DIF_W'(w_x2) - C_DIF_W'(w_bxmn);

        // Endpoint inside the grown box
        n_prep.flags.pt_in[0] = (w_x1e >= w_xmnlo) && (w_x1e <= w_xmxhi)
                             && (w_y1e >= w_ymnlo) && (w_y1e <= w_ymxhi);
        n_prep.flags.pt_in[1] = (w_x2e >= w_xmnlo) && (w_x2e <= w_xmxhi)
                             && (w_y2e >= w_ymnlo) && (w_y2e <= w_ymxhi);

        // Box coordinates inside the grown segment extent
        n_prep.flags.kx_in[0] = ((w_bxmn_e >= w_x1lo) || (w_bxmn_e >= w_x2lo))
                             && ((w_bxmn_e <= w_x1hi) || (w_bxmn_e <= w_x2hi));
        n_prep.flags.kx_in[1] = ((w_bxmx_e >= w_x1lo) || (w_bxmx_e >= w_x2lo))
                             && ((w_bxmx_e <= w_x1hi) || (w_bxmx_e <= w_x2hi));
        n_prep.flags.ky_in[0] = ((w_bymn_e >= w_y1lo) || (w_bymn_e >= w_y2lo))
                             && ((w_bymn_e <= w_y1hi) || (w_bymn_e <= w_y2hi));
        n_prep.flags.ky_in[1] = ((w_bymx_e >= w_y1lo) || (w_bymx_e >= w_y2lo))
                             && ((w_bymx_e <= w_y1hi) || (w_bymx_e <= w_y2hi));

        // Endpoints against the grown extent of each box edge
        n_prep.flags.x_span[0]     = (w_x1e >= w_xslo) && (w_x1e <= w_xshi);
        n_prep.flags.x_span[1]     = (w_x2e >= w_xslo) && (w_x2e <= w_xshi);
        n_prep.flags.y_span[0]     = (w_y1e >= w_yslo) && (w_y1e <= w_yshi);
        n_prep.flags.y_span[1]     = (w_y2e >= w_yslo) && (w_y2e <= w_yshi);
        n_prep.flags.x_near_min[0] = (w_x1e >= w_xmnlo) && (w_x1e <= w_xmnhi);
        n_prep.flags.x_near_min[1] = (w_x2e >= w_xmnlo) && (w_x2e <= w_xmnhi);
        n_prep.flags.x_near_max[0] = (w_x1e >= w_xmxlo) && (w_x1e <= w_xmxhi);
        n_prep.flags.x_near_max[1] = (w_x2e >= w_xmxlo) && (w_x2e <= w_xmxhi);
        n_prep.flags.y_near_min[0] = (w_y1e >= w_ymnlo) && (w_y1e <= w_ymnhi);
        n_prep.flags.y_near_min[1] = (w_y2e >= w_ymnlo) && (w_y2e <= w_ymnhi);
        n_prep.flags.y_near_max[0] = (w_y1e >= w_ymxlo) && (w_y1e <= w_ymxhi);
        n_prep.flags.y_near_max[1] = (w_y2e >= w_ymxlo) && (w_y2e <= w_ymxhi);
    end

    // Hold stage when the next stage is full
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prep <= n_prep;
        end
    end

    assign o_prep = r_prep;

endmodule

@@ rtl/sbo_orient.sv @@
// ============================================================================
// sbo_orient - orientation products and sign classification
// Stage two forms twelve exact products; stage three forms the corner
// orientations and classifies every orientation against the area tolerance.
// ============================================================================
module sbo_orient (
    input  logic                 i_clk,
    input  logic                 i_en_mul,
    input  logic                 i_en_sgn,
    input  sbo_pkg::t_prep_data  i_prep,
    input  sbo_pkg::t_box_cfg    i_cfg,
    output sbo_pkg::t_sign_set   o_sign
);
    import sbo_pkg::*;

    localparam int N_CRN = 4;
    localparam int N_EDG = 8;

    logic signed [C_PRD_W-1:0] r_pdx_ymn, r_pdx_ymx, r_pdy_xmn, r_pdy_xmx;
    logic signed [C_PRD_W-1:0] r_pe [N_EDG];
    t_prep_flags               r_flags;
    t_sign_set                 r_sign;
    t_sign_set                 n_sign;

    t_dif w_sdx, w_sdy, w_bdx, w_bdy;
    t_dif w_kxmn, w_kxmx, w_kymn, w_kymx;
    t_dif w_ed [N_EDG];
    logic signed [C_ORI_W-1:0] w_ok [N_CRN];
    logic signed [C_ORI_W-1:0] w_oe [N_EDG];
    logic signed [C_ORI_W-1:0] w_tp, w_tn;
    logic [N_EDG-1:0]          w_epos, w_eneg;

    assign w_sdx  = i_prep.seg_dx;
    assign w_sdy  = i_prep.seg_dy;
    assign w_bdx  = i_cfg.box_dx;
    assign w_bdy  = i_cfg.box_dy;
    assign w_kxmn = i_prep.kx_min;
    assign w_kxmx = i_prep.kx_max;
    assign w_kymn = i_prep.ky_min;
    assign w_kymx = i_prep.ky_max;
    assign w_ed[0] = i_prep.ed0_p0;
    assign w_ed[1] = i_prep.ed0_p1;
    assign w_ed[2] = i_prep.ed1_p0;
    assign w_ed[3] = i_prep.ed1_p1;
    assign w_ed[4] = i_prep.ed2_p0;
    assign w_ed[5] = i_prep.ed2_p1;
    assign w_ed[6] = i_prep.ed3_p0;
    assign w_ed[7] = i_prep.ed3_p1;

    // Multiply: corner terms share products, edges scale by box width/height
    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_pdx_ymn <= w_sdx * w_kymn;
            r_pdx_ymx <= w_sdx * w_kymx;
            r_pdy_xmn <= w_sdy * w_kxmn;
            r_pdy_xmx <= w_sdy * w_kxmx;
            r_pe[0]   <= w_bdx * w_ed[0];
            r_pe[1]   <= w_bdx * w_ed[1];
            r_pe[2]   <= w_bdy * w_ed[2];
            r_pe[3]   <= w_bdy * w_ed[3];
            r_pe[4]   <= w_bdx * w_ed[4];
            r_pe[5]   <= w_bdx * w_ed[5];
            r_pe[6]   <= w_bdy * w_ed[6];
            r_pe[7]   <= w_bdy * w_ed[7];
            r_flags   <= i_prep.flags;
        end
    end

    // Corner orientations: k0 (xmin,ymin), k1 (xmax,ymin), k2 (xmax,ymax), k3
    assign w_ok[0] = C_ORI_W'(r_pdx_ymn) - C_ORI_W'(r_pdy_xmn);
    assign w_ok[1] = C_ORI_W'(r_pdx_ymn) - C_ORI_W'(r_pdy_xmx);
    assign w_ok[2] = C_ORI_W'(r_pdx_ymx) - C_ORI_W'(r_pdy_xmx);
    assign w_ok[3] = C_ORI_W'(r_pdx_ymx) - C_ORI_W'(r_pdy_xmn);

    assign w_tp = C_ORI_W'(i_cfg.tol_a);
    assign w_tn = -w_tp;

    // Classify each orientation as positive, negative or zero
    always_comb begin
        n_sign = r_sign;
        for (int k = 0; k < N_CRN; k++) begin
            n_sign.k_pos[k] = w_ok[k] > w_tp;
            n_sign.k_neg[k] = w_ok[k] < w_tn;
        end
        for (int e = 0; e < N_EDG; e++) begin
            w_oe[e]   = C_ORI_W'(r_pe[e]);
            w_epos[e] = w_oe[e] > w_tp;
            w_eneg[e] = w_oe[e] < w_tn;
        end
        n_sign.e_pos0 = {w_epos[6], w_epos[4], w_epos[2], w_epos[0]};
        n_sign.e_neg0 = {w_eneg[6], w_eneg[4], w_eneg[2], w_eneg[0]};
        n_sign.e_pos1 = {w_epos[7], w_epos[5], w_epos[3], w_epos[1]};
        n_sign.e_neg1 = {w_eneg[7], w_eneg[5], w_eneg[3], w_eneg[1]};
        n_sign.flags  = r_flags;
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sgn) begin
            r_sign <= n_sign;
        end
    end

    assign o_sign = r_sign;

endmodule

@@ rtl/sbo_decide.sv @@
// ============================================================================
// sbo_decide - final rule selection
// Combines signs and range flags into the overlap verdict per box edge.
// ============================================================================
module sbo_decide (
    input  sbo_pkg::t_sign_set  i_sign,
    input  logic                i_degen,
    output logic                o_overlaps,
    output sbo_pkg::t_decide    o_decided_by
);
    import sbo_pkg::*;

    logic [3:0] w_kpn, w_knn;      // corner signs rotated: bit e is corner e+1
    logic [3:0] w_cross;
    logic [3:0] w_cok, w_kz_ok, w_ktouch;
    logic [3:0] w_ext0, w_ext1, w_etouch;
    logic [3:0] w_hit;
    t_prep_flags w_f;

    assign w_f   = i_sign.flags;
    assign w_kpn = {i_sign.k_pos[0], i_sign.k_pos[3:1]};
    assign w_knn = {i_sign.k_neg[0], i_sign.k_neg[3:1]};

    // Proper crossing: strict opposite signs on both segments
    assign w_cross = ((i_sign.k_pos & w_knn) | (i_sign.k_neg & w_kpn))
                   & ((i_sign.e_pos0 & i_sign.e_neg1) | (i_sign.e_neg0 & i_sign.e_pos1));

    // Corner touching the segment
    assign w_cok = {w_f.kx_in[0] & w_f.ky_in[1],
                    w_f.kx_in[1] & w_f.ky_in[1],
                    w_f.kx_in[1] & w_f.ky_in[0],
                    w_f.kx_in[0] & w_f.ky_in[0]};
    assign w_kz_ok  = ~(i_sign.k_pos | i_sign.k_neg) & w_cok;
    assign w_ktouch = w_kz_ok | {w_kz_ok[0], w_kz_ok[3:1]};

    // Endpoint touching an edge: bottom, right, top, left
    assign w_ext0 = {w_f.x_near_min[0] & w_f.y_span[0],
                     w_f.x_span[0]     & w_f.y_near_max[0],
                     w_f.x_near_max[0] & w_f.y_span[0],
                     w_f.x_span[0]     & w_f.y_near_min[0]};
    assign w_ext1 = {w_f.x_near_min[1] & w_f.y_span[1],
                     w_f.x_span[1]     & w_f.y_near_max[1],
                     w_f.x_near_max[1] & w_f.y_span[1],
                     w_f.x_span[1]     & w_f.y_near_min[1]};
    assign w_etouch = (~(i_sign.e_pos0 | i_sign.e_neg0) & w_ext0)
                    | (~(i_sign.e_pos1 | i_sign.e_neg1) & w_ext1);

    assign w_hit = w_cross | w_ktouch | w_etouch;

    // Pick the rule in priority order
    always_comb begin
        priority if (i_degen) begin
            o_decided_by = DEC_DEGEN;
        end else if (|w_f.pt_in) begin
            o_decided_by = DEC_POINT;
        end else if (|w_hit) begin
            o_decided_by = DEC_EDGE;
        end else begin
            o_decided_by = DEC_NONE;
        end
    end

    assign o_overlaps = (o_decided_by != DEC_NONE);

endmodule

@@ rtl/segment_box_overlap_test.sv @@
// ============================================================================
// segment_box_overlap_test - segment versus axis-aligned box overlap
// Tests each 2D segment against the configured box and reports the rule
// that decided the answer.
// ============================================================================
//
//  Channel   Direction  Handshake                 Beat contents
//  -------   ---------  ------------------------  -------------------------------
//  segment   in         i_seg_valid / o_seg_stall start_x, start_y, end_x, end_y
//  result    out        o_res_valid / i_res_stall overlaps, decided_by
//  config    in         psel/penable/pwrite/pready registers at 8-byte steps
//
//  One segment beat is taken every cycle while o_seg_stall is low; the result
//  passes through the input register, difference stage, multiplier stage, sign
//  stage and result register. The multiplier stage sets the cycle time.
//  Reset (synchronous, active low) empties the pipe and zeroes the box and
//  tolerance registers, which leaves a degenerate box. A stalled result holds
//  the result register; stages behind it keep filling empty slots, and
//  o_seg_stall rises only when the whole pipe is full.
//
module segment_box_overlap_test #(
    parameter int COORD_WIDTH = sbo_pkg::C_COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Segment channel
    input  logic                          i_seg_valid,
    output logic                          o_seg_stall,
    input  logic [31:0]                   i_start_x,
    input  logic [31:0]                   i_start_y,
    input  logic [31:0]                   i_end_x,
    input  logic [31:0]                   i_end_y,
    // Result channel
    output logic                          o_res_valid,
    input  logic                          i_res_stall,
    output logic                          o_overlaps,
    output logic [1:0]                    o_decided_by,
    // Register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sbo_pkg::C_CFG_AW-1:0]  paddr,
    input  logic [sbo_pkg::C_CFG_DW-1:0]  pwdata,
    output logic [sbo_pkg::C_CFG_DW-1:0]  prdata,
    output logic                          pready
);
    import sbo_pkg::*;

    localparam int CW = (COORD_WIDTH < C_CRD_W) ? COORD_WIDTH : C_CRD_W;

    logic [CW-1:0] r_x1, r_y1, r_x2, r_y2;
    logic          r_v0, r_v1, r_v2, r_v3, r_out_valid;
    logic          r_overlaps;
    t_decide       r_decided_by;

    logic          w_rdy0, w_rdy1, w_rdy2, w_rdy3, w_rdy4;
    logic          w_acc;
    t_box_cfg      w_cfg;
    t_prep_data    w_prep;
    t_sign_set     w_sign;
    logic          w_overlaps;
    t_decide       w_decided_by;

    // A stage may load when it is empty or the stage after it moves
    assign w_rdy4 = !r_out_valid || !i_res_stall;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign w_rdy0 = !r_v0 || w_rdy1;
    assign o_seg_stall = !w_rdy0;
    assign w_acc       = i_seg_valid && w_rdy0;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rdy0) r_v0        <= w_acc;
            if (w_rdy1) r_v1        <= r_v0;
            if (w_rdy2) r_v2        <= r_v1;
            if (w_rdy3) r_v3        <= r_v2;
            if (w_rdy4) r_out_valid <= r_v3;
        end
    end

    // Capture the segment beat
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_x1 <= i_start_x[CW-1:0];
            r_y1 <= i_start_y[CW-1:0];
            r_x2 <= i_end_x[CW-1:0];
            r_y2 <= i_end_y[CW-1:0];
        end
    end

    sbo_cfg_regs #(
        .COORD_W (CW)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sbo_prep #(
        .COORD_W (CW)
    ) u_prep (
        .i_clk  (i_clk),
        .i_en   (w_rdy1),
        .i_x1   (r_x1),
        .i_y1   (r_y1),
        .i_x2   (r_x2),
        .i_y2   (r_y2),
        .i_cfg  (w_cfg),
        .o_prep (w_prep)
    );

    sbo_orient u_orient (
        .i_clk    (i_clk),
        .i_en_mul (w_rdy2),
        .i_en_sgn (w_rdy3),
        .i_prep   (w_prep),
        .i_cfg    (w_cfg),
        .o_sign   (w_sign)
    );

    sbo_decide u_decide (
        .i_sign       (w_sign),
        .i_degen      (w_cfg.degen),
        .o_overlaps   (w_overlaps),
        .o_decided_by (w_decided_by)
    );

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_overlaps   <= w_overlaps;
            r_decided_by <= w_decided_by;
        end
    end

    assign o_res_valid  = r_out_valid;
    assign o_overlaps   = r_overlaps;
    assign o_decided_by = r_decided_by;

endmodule
